// File: hdl/rid_pkg.sv
`timescale 1ns / 1ps
// shared types, sizes and twiddle tables for the real input dft block
// no dependencies; every other file in hdl uses this package by scoped names
package rid_pkg;

	localparam int WIN_N    = 128;
	localparam int WIN_W    = $clog2(WIN_N);
	localparam int BINS     = WIN_N / 2;
	localparam int BIN_W    = 6;
	localparam int SMP_W    = 16;
	localparam int TW_W     = 16;
	localparam int PROD_W   = SMP_W + TW_W;
	localparam int ACC_W    = PROD_W + WIN_W + 1;
	localparam int RES_W    = 24;
	localparam int FRAC_W   = 15;
	localparam int WQ_DEPTH = 2;
	localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam int SERIES_TERMS = 12;

	typedef logic [63:0] u64_t;
	typedef logic signed [63:0] s64_t;
	typedef logic [WIN_N-1:0][TW_W-1:0] tw_tab_t;

	localparam u64_t Q31_ONE     = 64'd2147483648;
	localparam u64_t HALF_PI_Q31 = 64'd3373259426;

	// write request from the front into the window memory
	typedef struct packed {
		logic              en;
		logic              bank;
		logic [WIN_W-1:0]  addr;
		logic [SMP_W-1:0]  data;
	} wr_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} wq_stat_t;

	typedef struct packed {
		logic [BIN_W-1:0]        bin_index;
		logic signed [RES_W-1:0] real_part;
		logic signed [RES_W-1:0] imag_part;
		logic                    last_bin;
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DRAIN,
		BK_EMIT
	} back_state_t;

	// restoring long division, only evaluated while the twiddle tables are built
	function automatic u64_t udiv(input u64_t num, input u64_t den);
		u64_t quo;
		u64_t rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// taylor series of sin or cos in unsigned q2.31, clamped to [0, 1]
	function automatic u64_t series(input u64_t a, input bit is_sin);
		u64_t x2;
		u64_t term;
		u64_t dv;
		s64_t sum;
		x2   = (a * a) >> 31;
		term = is_sin ? a : Q31_ONE;
		sum  = $signed(term);
		for (int i = 1; i <= SERIES_TERMS; i++) begin
			dv   = is_sin ? 64'((2 * i) * (2 * i + 1)) : 64'((2 * i - 1) * (2 * i));
			term = udiv((term * x2) >> 31, dv);
			if (i % 2 == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		if (sum > $signed(Q31_ONE)) begin
			sum = $signed(Q31_ONE);
		end
		return $unsigned(sum);
	endfunction

	function automatic int to_q15(input u64_t v);
		return int'((64'd32767 * v + (Q31_ONE >> 1)) >> 31);
	endfunction

	// cosine table, or negated sine table, evaluated at elaboration
	function automatic tw_tab_t build_tab(input bit is_sin);
		int unsigned q;
		int unsigned r;
		u64_t        a;
		int          c;
		int          s;
		int          cv;
		int          sv;
		tw_tab_t     tab;
		tab = '0;
		for (int m = 0; m < WIN_N; m++) begin
			q = (4 * m) / WIN_N;
			r = 4 * m - q * WIN_N;
			a = (HALF_PI_Q31 * 64'(r)) / 64'(WIN_N);
			c = to_q15(series(a, 1'b0));
			s = to_q15(series(a, 1'b1));
			// exact one half at thirty and sixty degrees
			if (3 * r == WIN_N) begin
				s = 16384;
			end
			if (3 * r == 2 * WIN_N) begin
				c = 16384;
			end
			case (q % 4)
				0: begin
					cv = c;
					sv = s;
				end
				1: begin
					cv = -s;
					sv = c;
				end
				2: begin
					cv = -c;
					sv = -s;
				end
				default: begin
					cv = s;
					sv = -c;
				end
			endcase
			tab[m] = is_sin ? TW_W'(-sv) : TW_W'(cv);
		end
		return tab;
	endfunction

	localparam tw_tab_t COS_TAB  = build_tab(1'b0);
	localparam tw_tab_t NSIN_TAB = build_tab(1'b1);

endpackage

// File: hdl/rid_front.sv
`timescale 1ns / 1ps
// front end: takes samples, keeps the fill count and the bank being filled
// depends on rid_pkg
module rid_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       full,
	input  logic signed [rid_pkg::SMP_W-1:0] sample,
	output rid_pkg::wr_req_t           wr,
	output logic                       win_done
);

	logic [rid_pkg::WIN_W-1:0] fill_q;
	logic                      bank_q;
	logic                      take;
	logic                      at_end;

	assign take     = push && !full;
	assign at_end   = (fill_q == rid_pkg::WIN_W'(rid_pkg::WIN_N - 1));
	assign win_done = take && at_end;

	assign wr.en   = take;
	assign wr.bank = bank_q;
	assign wr.addr = fill_q;
	assign wr.data = sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bank_q <= 1'b0;
		end else if (take) begin
			if (at_end) begin
				fill_q <= '0;
				bank_q <= ~bank_q;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

// File: hdl/rid_wq.sv
`timescale 1ns / 1ps
// queue of full window banks between the front and the back
// depends on rid_pkg
module rid_wq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              win_push,
	input  logic              win_pop,
	output rid_pkg::wq_stat_t stat
);

	logic [rid_pkg::WQ_CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == rid_pkg::WQ_CNT_W'(rid_pkg::WQ_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (win_push && !win_pop) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (win_pop && !win_push) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: hdl/rid_back.sv
`timescale 1ns / 1ps
// back end: double banked window memory and one shared complex multiply-accumulate
// depends on rid_pkg
module rid_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rid_pkg::wr_req_t  wr,
	input  rid_pkg::wq_stat_t wq_stat,
	input  logic              oq_full,
	output logic              bank_rel,
	output logic              res_push,
	output rid_pkg::res_t     res
);

	logic [rid_pkg::SMP_W-1:0] win_mem [2*rid_pkg::WIN_N];

	rid_pkg::back_state_t state_q, state_nx;

	logic [rid_pkg::WIN_W-1:0] n_q;
	logic [rid_pkg::WIN_W-1:0] m_q;
	logic [rid_pkg::BIN_W-1:0] k_q;
	logic                      rd_bank_q;

	logic rd_en;
	logic acc_clr;
	logic last_k;

	logic                             v_s1, v_s2, v_s3;
	logic signed [rid_pkg::SMP_W-1:0] x_s1, x_s2;
	logic [rid_pkg::WIN_W-1:0]        m_s1;
	logic signed [rid_pkg::TW_W-1:0]  c_s2, s_s2;
	logic signed [rid_pkg::PROD_W-1:0] pr_s3, pi_s3;
	logic signed [rid_pkg::ACC_W-1:0] acc_re_q, acc_im_q;

	assign last_k = (k_q == rid_pkg::BIN_W'(rid_pkg::BINS - 1));

	always_ff @(posedge clk) begin
		if (wr.en) begin
			win_mem[{wr.bank, wr.addr}] <= wr.data;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rid_pkg::BK_IDLE: begin
				if (!wq_stat.empty) begin
					state_nx = rid_pkg::BK_RUN;
				end
			end
			rid_pkg::BK_RUN: begin
				if (n_q == rid_pkg::WIN_W'(rid_pkg::WIN_N - 1)) begin
					state_nx = rid_pkg::BK_DRAIN;
				end
			end
			rid_pkg::BK_DRAIN: begin
				if (!(v_s1 || v_s2 || v_s3)) begin
					state_nx = rid_pkg::BK_EMIT;
				end
			end
			rid_pkg::BK_EMIT: begin
				if (!oq_full) begin
					state_nx = last_k ? rid_pkg::BK_IDLE : rid_pkg::BK_RUN;
				end
			end
			default: state_nx = rid_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		rd_en    = (state_q == rid_pkg::BK_RUN);
		res_push = (state_q == rid_pkg::BK_EMIT) && !oq_full;
		bank_rel = res_push && last_k;
		acc_clr  = (state_q == rid_pkg::BK_IDLE) || res_push;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rid_pkg::BK_IDLE;
			n_q       <= '0;
			m_q       <= '0;
			k_q       <= '0;
			rd_bank_q <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
		end else begin
			state_q <= state_nx;
			v_s1    <= rd_en;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			if (state_q == rid_pkg::BK_IDLE) begin
				n_q <= '0;
				m_q <= '0;
				k_q <= '0;
			end else if (rd_en) begin
				n_q <= n_q + 1'b1;
				// twiddle index k*n mod N advances by k per sample
				m_q <= m_q + rid_pkg::WIN_W'(k_q);
			end else if (res_push) begin
				n_q <= '0;
				m_q <= '0;
				k_q <= k_q + 1'b1;
			end
			if (bank_rel) begin
				rd_bank_q <= ~rd_bank_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			x_s1 <= $signed(win_mem[{rd_bank_q, n_q}]);
		end
		m_s1 <= m_q;
		x_s2 <= x_s1;
		c_s2 <= $signed(rid_pkg::COS_TAB[m_s1]);
		s_s2 <= $signed(rid_pkg::NSIN_TAB[m_s1]);
		pr_s3 <= x_s2 * c_s2;
		pi_s3 <= x_s2 * s_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (acc_clr) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v_s3) begin
			acc_re_q <= acc_re_q + rid_pkg::ACC_W'(pr_s3);
			acc_im_q <= acc_im_q + rid_pkg::ACC_W'(pi_s3);
		end
	end

	// arithmetic shift floors the q15 sums
	assign res.bin_index = k_q;
	assign res.real_part = rid_pkg::RES_W'(acc_re_q >>> rid_pkg::FRAC_W);
	assign res.imag_part = rid_pkg::RES_W'(acc_im_q >>> rid_pkg::FRAC_W);
	assign res.last_bin  = last_k;

endmodule

// File: hdl/rid_outq.sv
`timescale 1ns / 1ps
// small result queue that decouples the back end from the result consumer
// depends on rid_pkg
module rid_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  rid_pkg::res_t res_in,
	input  logic          pop,
	output logic          oq_full,
	output logic          empty,
	output rid_pkg::res_t head
);

	rid_pkg::res_t mem_q [rid_pkg::OQ_DEPTH];

	logic [rid_pkg::OQ_PTR_W-1:0] wr_ptr_q;
	logic [rid_pkg::OQ_PTR_W-1:0] rd_ptr_q;
	logic [rid_pkg::OQ_CNT_W-1:0] cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign oq_full = (cnt_q == rid_pkg::OQ_CNT_W'(rid_pkg::OQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = res_push && !oq_full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/real_input_dft.sv
`timescale 1ns / 1ps
// Direct DFT over windows of 128 real signed 16-bit samples. Samples are
// pushed one at a time; when the 128th sample of a window is taken, bins 0
// to 63 come out in order, each with its floored Q15 real and imaginary
// sums, and last_bin marks bin 63. The window memory has two banks, so the
// next window fills while the current one is transformed; full rises only
// when both banks hold windows still waiting for their results. One shared
// multiply-accumulate reads one sample per cycle from the window memory while
// a bin is computed; each bin's 128 products are followed by pipeline drain
// and the write into the result queue.
// depends on rid_pkg, rid_front, rid_wq, rid_back, rid_outq
module real_input_dft (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [rid_pkg::SMP_W-1:0]    sample,
	output logic                                empty,
	input  logic                                pop,
	output logic [rid_pkg::BIN_W-1:0]           bin_index,
	output logic signed [rid_pkg::RES_W-1:0]    real_part,
	output logic signed [rid_pkg::RES_W-1:0]    imag_part,
	output logic                                last_bin
);

	rid_pkg::wr_req_t  wr;
	rid_pkg::wq_stat_t wq_stat;
	rid_pkg::res_t     res;
	rid_pkg::res_t     head;
	logic              win_done;
	logic              bank_rel;
	logic              res_push;
	logic              oq_full;

	assign full = wq_stat.full;

	rid_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (wq_stat.full),
		.sample   (sample),
		.wr       (wr),
		.win_done (win_done)
	);

	rid_wq u_wq (
		.clk      (clk),
		.arst_n   (arst_n),
		.win_push (win_done),
		.win_pop  (bank_rel),
		.stat     (wq_stat)
	);

	rid_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wq_stat  (wq_stat),
		.oq_full  (oq_full),
		.bank_rel (bank_rel),
		.res_push (res_push),
		.res      (res)
	);

	rid_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res),
		.pop      (pop),
		.oq_full  (oq_full),
		.empty    (empty),
		.head     (head)
	);

	assign bin_index = head.bin_index;
	assign real_part = head.real_part;
	assign imag_part = head.imag_part;
	assign last_bin  = head.last_bin;

`ifndef SYNTHESIS
	a_no_wq_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(win_done && wq_stat.full))
		else $error("window completed while both banks are occupied");

	a_release_needs_window: assert property (@(posedge clk) disable iff (!arst_n)
		bank_rel |-> !wq_stat.empty)
		else $error("bank released with no window queued");

	a_last_bin_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_bin) |-> (bin_index == rid_pkg::BIN_W'(rid_pkg::BINS - 1)))
		else $error("last bin flag on wrong bin");
`endif

endmodule

// File: tb/real_input_dft_tb.sv
`timescale 1ns / 1ps
// self-checking bench for real_input_dft: a queue-fed driver pushes samples in bursts,
// a monitor pops bins and compares them with a direct dft worked out in the bench
// depends on rid_pkg for port widths and the result struct, and on the real_input_dft rtl
module real_input_dft_tb;

	localparam int N           = rid_pkg::WIN_N;
	localparam int NBINS       = N / 2;
	localparam int N_ITEMS     = 2 * N + 8;
	localparam int PAUSE_AT    = 2 * N + 4;
	localparam int HOLD_CYCLES = 20000;
	localparam int MAX_REPORTS = 10;
	localparam int TERMS       = 12;
	localparam longint unsigned Q31_UNIT     = 64'd2147483648;
	localparam longint unsigned QUARTER_Q31  = 64'd3373259426;

	localparam logic signed [rid_pkg::SMP_W-1:0] EDGE_SAMPLES [25] = '{
		32767, -32768, 0, -1, 1, 21845, -21846, 256, -256, 16384, -16384, 8191, -8192,
		32767, 32767, -32768, -32768, 4096, 0, 0, 12345, -12345, 1000, -1000, 2
	};

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_PATTERN,
		RX_RANDOM
	} rx_mode_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                push = 1'b0;
	logic                                full;
	logic signed [rid_pkg::SMP_W-1:0]    sample = '0;
	logic                                empty;
	logic                                pop = 1'b0;
	logic [rid_pkg::BIN_W-1:0]           bin_index;
	logic signed [rid_pkg::RES_W-1:0]    real_part;
	logic signed [rid_pkg::RES_W-1:0]    imag_part;
	logic                                last_bin;

	// twiddles in q1.15 and the bench copy of the window
	int                                  cos_q15 [N];
	int                                  sin_q15 [N];
	logic signed [rid_pkg::SMP_W-1:0]    win_smp [N];
	int                                  fill_pos = 0;

	logic signed [rid_pkg::SMP_W-1:0]    pending_smp [$];
	rid_pkg::res_t                       bins_due [$];
	int                                  n_errors = 0;

	int                                  burst_left = 0;
	int                                  gap_left = 0;
	int                                  n_sent = 0;
	rx_mode_t                            rx_mode = RX_STEADY;
	int                                  rx_left = 0;
	logic [15:0]                         rx_pattern = 16'h0001;
	logic                                hold_started = 1'b0;
	int                                  hold_left = 0;

	real_input_dft dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.empty     (empty),
		.pop       (pop),
		.bin_index (bin_index),
		.real_part (real_part),
		.imag_part (imag_part),
		.last_bin  (last_bin)
	);

	always #4 clk = ~clk;

	// truncated taylor series in unsigned q2.31, clamped to [0, 1]
	function automatic longint unsigned q31_series(input longint unsigned a, input bit sine);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned dv;
		longint          acc;
		int              i;
		x2   = (a * a) >> 31;
		term = sine ? a : Q31_UNIT;
		acc  = longint'(term);
		for (i = 1; i <= TERMS; i++) begin
			dv   = sine ? longint'((2 * i) * (2 * i + 1)) : longint'((2 * i - 1) * (2 * i));
			term = ((term * x2) >> 31) / dv;
			if (i % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > longint'(Q31_UNIT)) begin
			acc = longint'(Q31_UNIT);
		end
		return unsigned'(acc);
	endfunction

	function automatic int q31_to_q15(input longint unsigned v);
		return int'((64'd32767 * v + (Q31_UNIT >> 1)) >> 31);
	endfunction

	function automatic void build_twiddles();
		int unsigned     q;
		int unsigned     r;
		longint unsigned a;
		int              c;
		int              s;
		int              m;
		for (m = 0; m < N; m++) begin
			q = (4 * m) / N;
			r = 4 * m - q * N;
			a = (QUARTER_Q31 * 64'(r)) / 64'(N);
			c = q31_to_q15(q31_series(a, 1'b0));
			s = q31_to_q15(q31_series(a, 1'b1));
			// thirty and sixty degrees are pinned to exactly one half
			if (3 * r == N) begin
				s = 16384;
			end
			if (3 * r == 2 * N) begin
				c = 16384;
			end
			case (q % 4)
				0: begin
					cos_q15[m] = c;
					sin_q15[m] = s;
				end
				1: begin
					cos_q15[m] = -s;
					sin_q15[m] = c;
				end
				2: begin
					cos_q15[m] = -c;
					sin_q15[m] = -s;
				end
				default: begin
					cos_q15[m] = s;
					sin_q15[m] = -c;
				end
			endcase
		end
	endfunction

	// store one sample; on the last of a window, queue bins 0 to N/2-1
	function automatic void take_sample(input logic signed [rid_pkg::SMP_W-1:0] x);
		longint        acc_re;
		longint        acc_im;
		int            idx;
		int            k;
		int            i;
		rid_pkg::res_t due;
		win_smp[fill_pos] = x;
		fill_pos++;
		if (fill_pos == N) begin
			fill_pos = 0;
			for (k = 0; k < NBINS; k++) begin
				acc_re = 0;
				acc_im = 0;
				for (i = 0; i < N; i++) begin
					idx    = (k * i) % N;
					acc_re = acc_re + longint'(win_smp[i]) * cos_q15[idx];
					acc_im = acc_im + longint'(win_smp[i]) * (-sin_q15[idx]);
				end
				due.bin_index = rid_pkg::BIN_W'(k);
				due.real_part = rid_pkg::RES_W'(acc_re >>> 15);
				due.imag_part = rid_pkg::RES_W'(acc_im >>> 15);
				due.last_bin  = (k == NBINS - 1);
				bins_due.push_back(due);
			end
		end
	endfunction

	function automatic void report_error(input string msg);
		n_errors++;
		if (n_errors <= MAX_REPORTS) begin
			$display("error at %0t ns: %s", $time, msg);
		end
	endfunction

	// sender: bursts of requests with gaps, one pause until all bins are back
	always @(posedge clk or negedge arst_n) begin : drive
		bit offer;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			offer = 1'b0;
			if (push && !full) begin
				take_sample(sample);
				void'(pending_smp.pop_front());
				n_sent++;
				if (burst_left > 0) begin
					burst_left--;
				end
			end
			if (push && full) begin
				offer = 1'b1;
			end else if (pending_smp.size() == 0) begin
				offer = 1'b0;
			end else if (n_sent == PAUSE_AT && bins_due.size() != 0) begin
				offer = 1'b0;
			end else begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					offer = 1'b1;
				end
			end
			push <= offer;
			if (offer) begin
				sample <= pending_smp[0];
			end
		end
	end

	// one long receiver hold-off from the first bin, so both banks fill and full rises
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_started <= 1'b0;
			hold_left    <= 0;
		end else if (!hold_started && !empty) begin
			hold_started <= 1'b1;
			hold_left    <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver: checks each popped bin, then picks pop from its own stall pattern
	always @(posedge clk or negedge arst_n) begin : collect
		rid_pkg::res_t want;
		bit            take;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (bins_due.size() == 0) begin
					report_error($sformatf("bin %0d popped with none outstanding", bin_index));
				end else begin
					want = bins_due.pop_front();
					if (bin_index !== want.bin_index) begin
						report_error($sformatf("bin_index exp %0d got %0d",
							want.bin_index, bin_index));
					end
					if (real_part !== want.real_part) begin
						report_error($sformatf("bin %0d real_part exp %0d got %0d",
							want.bin_index, want.real_part, real_part));
					end
					if (imag_part !== want.imag_part) begin
						report_error($sformatf("bin %0d imag_part exp %0d got %0d",
							want.bin_index, want.imag_part, imag_part));
					end
					if (last_bin !== want.last_bin) begin
						report_error($sformatf("bin %0d last_bin exp %0d got %0d",
							want.bin_index, want.last_bin, last_bin));
					end
				end
			end
			if (rx_left == 0) begin
				rx_mode    = rx_mode_t'($urandom_range(0, 2));
				rx_left    = $urandom_range(8, 200);
				rx_pattern = 16'($urandom) | 16'h0001;
			end
			rx_left--;
			rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
			case (rx_mode)
				RX_STEADY: begin
					take = 1'b1;
				end
				RX_PATTERN: begin
					take = rx_pattern[0];
				end
				default: begin
					take = ($urandom_range(0, 3) != 0);
				end
			endcase
			if (hold_left != 0 || (!hold_started && !empty)) begin
				take = 1'b0;
			end
			pop <= take;
		end
	end

	initial begin : run
		int i;
		int pick;
		build_twiddles();
		// first window: field extremes, then uniform noise
		foreach (EDGE_SAMPLES[j]) begin
			pending_smp.push_back(EDGE_SAMPLES[j]);
		end
		for (i = $size(EDGE_SAMPLES); i < N; i++) begin
			pending_smp.push_back(16'($urandom));
		end
		// second window at full negative scale gives the largest bin magnitude
		for (i = 0; i < N; i++) begin
			pending_smp.push_back(-16'sd32767 - 16'sd1);
		end
		// start of a third window: rail values, small values and noise
		for (i = 2 * N; i < N_ITEMS; i++) begin
			pick = $urandom_range(0, 3);
			if (pick == 0) begin
				pending_smp.push_back($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
			end else if (pick == 1) begin
				pending_smp.push_back(16'($urandom_range(0, 15) - 8));
			end else begin
				pending_smp.push_back(16'($urandom));
			end
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (pending_smp.size() != 0 || bins_due.size() != 0);
		repeat (400) @(posedge clk);
		if (n_errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
